/* rtl/core/wgm_pkg.sv */
// wgm_pkg: shared constants and controller/datapath interface types
// for the wildcard glob matcher; no dependencies
`default_nettype none

package wgm_pkg;

   localparam int PATTERN_DEPTH_DEF = 64;
   localparam int SUBJECT_DEPTH_DEF = 256;
   localparam int CHAR_BITS_DEF     = 16;

   // width of the character field on the request port
   localparam int CH_W = 16;

   localparam logic [CH_W-1:0] STAR_CODE  = 16'h002A;
   localparam logic [CH_W-1:0] QMARK_CODE = 16'h003F;

   // controller to datapath
   typedef struct packed {
      logic load;    // accepted transaction, store character
      logic start;   // clear walk pointers
      logic step;    // apply one walk step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;       // walk has reached a verdict
      logic hit;        // verdict: whole subject matches
      logic overflow;   // either store was truncated
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/wgm_datapath.sv */
// wgm_datapath: pattern and subject stores, length tracking and the
// backtracking walk step; depends on wgm_pkg
`default_nettype none

module wgm_datapath #(
   parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF,
   parameter int SUBJECT_DEPTH = wgm_pkg::SUBJECT_DEPTH_DEF,
   parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_func,
   input  wire [wgm_pkg::CH_W-1:0] req_ch,
   input  wire                     req_has_char,
   input  wire                     req_last,
   input  wire wgm_pkg::cmd_type   cmd,
   output wgm_pkg::status_type     status
);
   import wgm_pkg::*;

   localparam int PCW = $clog2(PATTERN_DEPTH + 1);
   localparam int SCW = $clog2(SUBJECT_DEPTH + 1);
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

   localparam logic [CHAR_BITS-1:0] STAR_C  = CHAR_BITS'(STAR_CODE);
   localparam logic [CHAR_BITS-1:0] QMARK_C = CHAR_BITS'(QMARK_CODE);

   logic [CHAR_BITS-1:0] pat_mem [PATTERN_DEPTH];
   logic [CHAR_BITS-1:0] sub_mem [SUBJECT_DEPTH];
   logic [CHAR_BITS-1:0] pat_rd_ff, sub_rd_ff;

   logic [PCW-1:0] pat_len_ff, pat_len_in;
   logic           pat_done_ff, pat_done_in;
   logic           pat_ovf_ff, pat_ovf_in;
   logic [SCW-1:0] sub_len_ff, sub_len_in;
   logic           sub_done_ff, sub_done_in;
   logic           sub_ovf_ff, sub_ovf_in;

   logic [PCW-1:0] p_ff, p_in, rp_ff, rp_in;
   logic [SCW-1:0] s_ff, s_in, rs_ff, rs_in;
   logic           walk_ff, walk_in;

   logic [CHAR_BITS-1:0] ch_val;
   logic [PCW-1:0]       pl_base;
   logic [SCW-1:0]       sl_base;
   logic                 pat_we, sub_we;
   logic                 pv, sv, is_star, fits;
   logic [PCW-1:0]       p_inc;
   logic                 done_c, hit_c;

   assign ch_val  = CHAR_BITS'(req_ch);
   assign pl_base = pat_done_ff ? '0 : pat_len_ff;
   assign sl_base = sub_done_ff ? '0 : sub_len_ff;
   assign pat_we  = cmd.load && !req_func && req_has_char && (pl_base < PCW'(PATTERN_DEPTH));
   assign sub_we  = cmd.load && req_func && req_has_char && (sl_base < SCW'(SUBJECT_DEPTH));

   // store loading
   always_comb begin
      pat_len_in  = pat_len_ff;
      pat_done_in = pat_done_ff;
      pat_ovf_in  = pat_ovf_ff;
      sub_len_in  = sub_len_ff;
      sub_done_in = sub_done_ff;
      sub_ovf_in  = sub_ovf_ff;
      if (cmd.load && !req_func) begin
         pat_len_in  = pl_base;
         pat_ovf_in  = pat_done_ff ? 1'b0 : pat_ovf_ff;
         pat_done_in = req_last;
         if (req_has_char) begin
            if (pat_we) pat_len_in = pl_base + 1'b1;
            else        pat_ovf_in = 1'b1;
         end
      end
      if (cmd.load && req_func) begin
         sub_len_in  = sl_base;
         sub_ovf_in  = sub_done_ff ? 1'b0 : sub_ovf_ff;
         sub_done_in = req_last;
         if (req_has_char) begin
            if (sub_we) sub_len_in = sl_base + 1'b1;
            else        sub_ovf_in = 1'b1;
         end
      end
   end

   // one walk step
   assign pv      = p_ff < pat_len_ff;
   assign sv      = s_ff < sub_len_ff;
   assign is_star = pv && (pat_rd_ff == STAR_C);
   assign fits    = pv && ((pat_rd_ff == sub_rd_ff) || (pat_rd_ff == QMARK_C));
   assign p_inc   = p_ff + 1'b1;

   always_comb begin
      p_in    = p_ff;
      s_in    = s_ff;
      rp_in   = rp_ff;
      rs_in   = rs_ff;
      walk_in = walk_ff;
      done_c  = 1'b0;
      hit_c   = 1'b0;
      if (!sv) begin
         if (is_star) begin
            p_in = p_inc;
         end else begin
            done_c = 1'b1;
            hit_c  = !pv;
         end
      end else if (is_star) begin
         if (p_inc >= pat_len_ff) begin
            done_c = 1'b1;
            hit_c  = 1'b1;
         end else begin
            p_in    = p_inc;
            rp_in   = p_inc;
            rs_in   = s_ff + 1'b1;
            walk_in = 1'b1;
         end
      end else if (fits) begin
         p_in = p_inc;
         s_in = s_ff + 1'b1;
      end else if (!walk_ff) begin
         done_c = 1'b1;
      end else begin
         p_in  = rp_ff;
         s_in  = rs_ff;
         rs_in = rs_ff + 1'b1;
      end
   end

   assign status.done     = done_c;
   assign status.hit      = hit_c;
   assign status.overflow = pat_ovf_ff || sub_ovf_ff;

   // stores with registered read
   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pl_base[PAW-1:0]] <= ch_val;
      pat_rd_ff <= pat_mem[p_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sub_we) sub_mem[sl_base[SAW-1:0]] <= ch_val;
      sub_rd_ff <= sub_mem[s_ff[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         pat_done_ff <= 1'b1;
         pat_ovf_ff  <= 1'b0;
         sub_len_ff  <= '0;
         sub_done_ff <= 1'b1;
         sub_ovf_ff  <= 1'b0;
         p_ff        <= '0;
         s_ff        <= '0;
         rp_ff       <= '0;
         rs_ff       <= '0;
         walk_ff     <= 1'b0;
      end else begin
         pat_len_ff  <= pat_len_in;
         pat_done_ff <= pat_done_in;
         pat_ovf_ff  <= pat_ovf_in;
         sub_len_ff  <= sub_len_in;
         sub_done_ff <= sub_done_in;
         sub_ovf_ff  <= sub_ovf_in;
         if (cmd.start) begin
            p_ff    <= '0;
            s_ff    <= '0;
            rp_ff   <= '0;
            rs_ff   <= '0;
            walk_ff <= 1'b0;
         end else if (cmd.step) begin
            p_ff    <= p_in;
            s_ff    <= s_in;
            rp_ff   <= rp_in;
            rs_ff   <= rs_in;
            walk_ff <= walk_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/wgm_ctrl.sv */
// wgm_ctrl: sequencer for loading, the match walk and the result register
// depends on wgm_pkg
`default_nettype none

module wgm_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_func,
   input  wire                      req_last,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_matched,
   output logic                     rsp_overflow,
   output wgm_pkg::cmd_type         cmd,
   input  wire wgm_pkg::status_type status
);
   import wgm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff, rsp_matched_ff, rsp_overflow_ff;
   logic      accept, out_free, rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_EVAL) && status.done && out_free;

   assign cmd.load  = accept;
   assign cmd.start = accept && req_func && req_last;
   assign cmd.step  = (state_ff == ST_EVAL) && !status.done;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_matched_ff  <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff    <= 1'b1;
            rsp_matched_ff  <= status.hit;
            rsp_overflow_ff <= status.overflow;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.start) state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (!status.done) begin
                  state_ff <= ST_READ;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/core/wildcard_glob_matcher.sv */
// wildcard_glob_matcher: whole-string '*' / '?' matcher, top level over wgm_ctrl and wgm_datapath
// loading handles one accepted transaction at a time; the last subject transaction then starts the walk
// in steps (store read, then evaluate), up to about pattern_length *
// subject_length steps plus the tail; the verdict step itself loads the result register
// requests are stalled during the walk and while a finished verdict waits for the result
// register; synchronous active-high reset empties both stores; depends on wgm_pkg
`default_nettype none

module wildcard_glob_matcher #(
   parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF,
   parameter int SUBJECT_DEPTH = wgm_pkg::SUBJECT_DEPTH_DEF,
   parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_func,
   input  wire [wgm_pkg::CH_W-1:0] req_ch,
   input  wire                     req_has_char,
   input  wire                     req_last,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_matched,
   output logic                    rsp_overflow
);
   import wgm_pkg::*;

   cmd_type    cmd;
   status_type status;

   wgm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow),
      .cmd          (cmd),
      .status       (status)
   );

   wgm_datapath #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .SUBJECT_DEPTH (SUBJECT_DEPTH),
      .CHAR_BITS     (CHAR_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_func     (req_func),
      .req_ch       (req_ch),
      .req_has_char (req_has_char),
      .req_last     (req_last),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

`default_nettype wire

/* dv/wildcard_glob_matcher_tb.sv */
// tb: self-checking testbench for wildcard_glob_matcher, a directed table then random
// pattern/subject sequences, results checked vs typed verdicts or a glob predictor
// depends on wgm_pkg and the wildcard_glob_matcher rtl
`timescale 1ns / 1ps

module tb;
   import wgm_pkg::*;

   localparam logic FUNC_PATTERN   = 1'b0;
   localparam logic FUNC_SUBJECT   = 1'b1;
   localparam int   PAT_DEPTH      = PATTERN_DEPTH_DEF;
   localparam int   SUBJ_DEPTH     = SUBJECT_DEPTH_DEF;
   localparam int   RANDOM_ITEMS   = 650;
   localparam int   WATCHDOG_LIMIT = 200000;
   localparam int   DRAIN_CYCLES   = 100;
   localparam int   DIRECTED_ROWS  = 24;

   typedef logic [CH_W-1:0] text_type [$];

   typedef struct packed {
      logic            func;
      logic [CH_W-1:0] ch;
      logic            has_char;
      logic            last;
      int              reps;
      logic            typed;
      logic            matched;
      logic            overflow;
   } stim_row_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   // last is applied on the final repetition of a row only
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{FUNC_SUBJECT, 16'h0000,   1'b0, 1'b1, 1,   1'b1, 1'b1, 1'b0},
      '{FUNC_SUBJECT, 16'h0061,   1'b1, 1'b1, 1,   1'b1, 1'b0, 1'b0},
      '{FUNC_PATTERN, STAR_CODE,  1'b1, 1'b1, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0000,   1'b0, 1'b1, 1,   1'b1, 1'b1, 1'b0},
      '{FUNC_SUBJECT, 16'h0061,   1'b1, 1'b1, 257, 1'b1, 1'b1, 1'b1},
      '{FUNC_PATTERN, STAR_CODE,  1'b1, 1'b1, 65,  1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h007A,   1'b1, 1'b1, 1,   1'b1, 1'b1, 1'b1},
      '{FUNC_PATTERN, 16'h0061,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0061,   1'b1, 1'b1, 1,   1'b1, 1'b1, 1'b0},
      '{FUNC_PATTERN, 16'h0062,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 16'h0000,   1'b0, 1'b1, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0061,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0042,   1'b1, 1'b1, 1,   1'b1, 1'b0, 1'b0},
      '{FUNC_PATTERN, 16'h0000,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, QMARK_CODE, 1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, STAR_CODE,  1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 16'hFFFF,   1'b1, 1'b1, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0000,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h8001,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h7FFE,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'hFFFF,   1'b1, 1'b1, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0000,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h5A5A,   1'b1, 1'b0, 1,   1'b0, 1'b0, 1'b0},
      '{FUNC_SUBJECT, 16'h0000,   1'b0, 1'b1, 1,   1'b0, 1'b0, 1'b0}
   };

   logic            clock        = 1'b0;
   logic            reset        = 1'b1;
   logic            req_valid    = 1'b0;
   logic            req_func     = 1'b0;
   logic [CH_W-1:0] req_ch       = '0;
   logic            req_has_char = 1'b0;
   logic            req_last     = 1'b0;
   logic            rsp_stall    = 1'b0;
   logic            req_stall;
   logic            rsp_valid;
   logic            rsp_matched;
   logic            rsp_overflow;

   // hand-typed verdict travelling with the transaction
   logic            row_typed    = 1'b0;
   logic            row_matched  = 1'b0;
   logic            row_overflow = 1'b0;

   logic [CH_W-1:0] pat_mem  [PAT_DEPTH];
   logic [CH_W-1:0] subj_mem [SUBJ_DEPTH];
   int unsigned     pat_len, subj_len;
   bit              pat_done, pat_ovf, subj_done, subj_ovf;

   verdict_type     verdicts_due [$];
   verdict_type     due;
   bit              emit_now, m_pred, o_pred;
   int              fails        = 0;
   int              sent         = 0;
   int              burst_left   = 0;
   int              quiet_cycles = 0;
   int              stall_mode   = 0;
   int              stall_left   = 0;

   wildcard_glob_matcher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_ch       (req_ch),
      .req_has_char (req_has_char),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit pat_star(int unsigned p);
      return p < pat_len && pat_mem[p] == STAR_CODE;
   endfunction

   function automatic bit pat_fits(int unsigned p, int unsigned s);
      return p < pat_len && (pat_mem[p] == subj_mem[s] || pat_mem[p] == QMARK_CODE);
   endfunction

   // greedy walk, backtracking to the most recent star
   function automatic bit glob_match();
      int unsigned p, s, rp, rs;
      p  = 0;
      s  = 0;
      rp = 0;
      rs = 0;
      while (s < subj_len && !pat_star(p)) begin
         if (!pat_fits(p, s)) return 1'b0;
         p++;
         s++;
      end
      while (s < subj_len) begin
         if (pat_star(p)) begin
            p++;
            if (p >= pat_len) return 1'b1;
            rp = p;
            rs = s + 1;
         end else if (pat_fits(p, s)) begin
            p++;
            s++;
         end else begin
            p = rp;
            s = rs;
            rs++;
         end
      end
      while (pat_star(p)) p++;
      return p >= pat_len;
   endfunction

   task automatic glob_step(input logic func, input logic [CH_W-1:0] ch, input logic has,
                            input logic last, output bit emit, output bit m, output bit o);
      emit = 1'b0;
      m    = 1'b0;
      o    = 1'b0;
      if (func == FUNC_PATTERN) begin
         if (pat_done) begin
            pat_len  = 0;
            pat_ovf  = 1'b0;
            pat_done = 1'b0;
         end
         if (has) begin
            if (pat_len < PAT_DEPTH) begin
               pat_mem[pat_len] = ch;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         if (last) pat_done = 1'b1;
      end else begin
         if (subj_done) begin
            subj_len  = 0;
            subj_ovf  = 1'b0;
            subj_done = 1'b0;
         end
         if (has) begin
            if (subj_len < SUBJ_DEPTH) begin
               subj_mem[subj_len] = ch;
               subj_len++;
            end else begin
               subj_ovf = 1'b1;
            end
         end
         if (last) begin
            subj_done = 1'b1;
            emit      = 1'b1;
            m         = glob_match();
            o         = pat_ovf || subj_ovf;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_len   = 0;
         pat_done  = 1'b1;
         pat_ovf   = 1'b0;
         subj_len  = 0;
         subj_done = 1'b1;
         subj_ovf  = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            glob_step(req_func, req_ch, req_has_char, req_last, emit_now, m_pred, o_pred);
            if (emit_now) begin
               if (row_typed) verdicts_due.push_back('{row_matched, row_overflow});
               else verdicts_due.push_back('{m_pred, o_pred});
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $error("result with no transaction pending: matched %0b overflow %0b",
                      rsp_matched, rsp_overflow);
               fails++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_matched !== due.matched) begin
                  $error("matched: expected %0b, got %0b", due.matched, rsp_matched);
                  fails++;
               end
               if (rsp_overflow !== due.overflow) begin
                  $error("overflow: expected %0b, got %0b", due.overflow, rsp_overflow);
                  fails++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: free-flowing, light random or heavy random stall stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   task automatic send_txn(input logic func, input logic [CH_W-1:0] ch, input logic has,
                           input logic last, input logic typed, input logic m,
                           input logic o);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_ch       <= ch;
      req_has_char <= has;
      req_last     <= last;
      row_typed    <= typed;
      row_matched  <= m;
      row_overflow <= o;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   function automatic logic [CH_W-1:0] pattern_char();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return STAR_CODE;
      if (r < 25) return QMARK_CODE;
      if (r < 40) return CH_W'($urandom_range(0, 65535));
      return 16'h0061 + CH_W'($urandom_range(0, 2));
   endfunction

   function automatic logic [CH_W-1:0] subject_char();
      if ($urandom_range(0, 6) == 0) return CH_W'($urandom_range(0, 65535));
      return 16'h0061 + CH_W'($urandom_range(0, 2));
   endfunction

   // sometimes the sequence is closed by a separate no-character transaction
   task automatic send_text(input logic func, input text_type txt);
      bit split_end;
      split_end = (txt.size() == 0) || ($urandom_range(0, 7) == 0);
      foreach (txt[i])
         send_txn(func, txt[i], 1'b1, !split_end && i == txt.size() - 1, 1'b0, 1'b0, 1'b0);
      if (split_end)
         send_txn(func, CH_W'($urandom_range(0, 65535)), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
   endtask

   initial begin : stimulus
      text_type pat_q, subj_q;
      int       random_end;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         for (int k = 0; k < DIRECTED[i].reps; k++)
            send_txn(DIRECTED[i].func, DIRECTED[i].ch, DIRECTED[i].has_char,
                     DIRECTED[i].last && k == DIRECTED[i].reps - 1, DIRECTED[i].typed,
                     DIRECTED[i].matched, DIRECTED[i].overflow);

      random_end = sent + RANDOM_ITEMS;
      while (sent < random_end) begin
         if ($urandom_range(0, 9) == 0) begin
            send_txn(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'b0, 1'b0, 1'b0);
         end else begin
            pat_q.delete();
            repeat (($urandom_range(0, 24) == 0) ? $urandom_range(60, 68)
                                                 : $urandom_range(0, 8))
               pat_q.push_back(pattern_char());
            send_text(FUNC_PATTERN, pat_q);
            repeat ($urandom_range(1, 4)) begin
               subj_q.delete();
               if ($urandom_range(0, 29) == 0) begin
                  repeat ($urandom_range(250, 262)) subj_q.push_back(subject_char());
               end else if ($urandom_range(0, 1) == 1) begin
                  // expand the pattern into a subject that should mostly match
                  foreach (pat_q[i]) begin
                     if (pat_q[i] == STAR_CODE)
                        repeat ($urandom_range(0, 3)) subj_q.push_back(subject_char());
                     else if (pat_q[i] == QMARK_CODE)
                        subj_q.push_back(subject_char());
                     else
                        subj_q.push_back(pat_q[i]);
                  end
               end else begin
                  repeat ($urandom_range(0, 10)) subj_q.push_back(subject_char());
               end
               send_text(FUNC_SUBJECT, subj_q);
            end
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
